FILE: rtl/bkrc_pkg.sv
// ----------------------------------------------------------------------------
// bkrc_pkg
// Shared types and codes of the batched keyed reference counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bkrc_pkg;

   localparam int unsigned PENDING_DEPTH_DEF = 16;
   localparam int unsigned TABLE_DEPTH_DEF   = 64;

   // request commands
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_COMMIT = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_CREATED   = 3'd0;
   localparam logic [2:0] KIND_CHANGED   = 3'd1;
   localparam logic [2:0] KIND_DESTROYED = 3'd2;
   localparam logic [2:0] KIND_QUERY     = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;
   localparam logic [2:0] KIND_PEND_FULL = 3'd5;
   localparam logic [2:0] KIND_TAB_FULL  = 3'd6;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_P_SCAN  = 6'b000010,
      ST_C_NEXT  = 6'b000100,
      ST_T_SCAN  = 6'b001000,
      ST_RESOLVE = 6'b010000,
      ST_EMIT2   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/bkrc_ram.sv
// ----------------------------------------------------------------------------
// bkrc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bkrc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/batched_keyed_reference_counter.sv
// ----------------------------------------------------------------------------
// batched_keyed_reference_counter
// Keyed reference counter: adds collect per-key deltas in a pending list,
// a commit applies them to a counted table, a query reads one count.
// ----------------------------------------------------------------------------
// Add: one pending entry compared per cycle.
// Query: one table slot read per cycle from the RAM.
// Commit: each non-zero pending entry runs a table scan and may emit two events,
//   zero entries are skipped; the table scan sets the rate.
// Results appear on rsp_valid, at most one per cycle; the receiver cannot stall.
// Synchronous reset empties the pending list and the table at once.
`default_nettype none

module batched_keyed_reference_counter
   import bkrc_pkg::*;
#(
   parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF,
   parameter int unsigned TABLE_DEPTH   = TABLE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [31:0]        req_key,
   input  wire logic signed [31:0] req_delta,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_kind,
   output logic [31:0]             rsp_entry_key,
   output logic signed [31:0]      rsp_count,
   output logic signed [31:0]      rsp_applied_delta,
   output logic                    rsp_last
);

   localparam int unsigned PIW = $clog2(PENDING_DEPTH);
   localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
   localparam int unsigned TIW = $clog2(TABLE_DEPTH);
   localparam int unsigned TCW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned RW  = 63;

   state_type state_ff, state_in;

   // latched request
   logic [1:0]         cmd_ff, cmd_in;
   logic [31:0]        key_ff, key_in;
   logic signed [31:0] sum_ff, sum_in;

   // pending list
   logic [31:0]        pkeys_ff [PENDING_DEPTH];
   logic signed [31:0] psums_ff [PENDING_DEPTH];
   logic [PCW-1:0]     used_ff, used_in;
   logic [PCW-1:0]     pidx_ff, pidx_in;
   logic               pwr_en;
   logic [PIW-1:0]     pwr_idx;
   logic [31:0]        pwr_key;
   logic signed [31:0] pwr_sum;

   // table scan
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TCW-1:0]         tidx_ff, tidx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [TIW-1:0]         chk_idx_ff, chk_idx_in;
   logic                   found_ff, found_in;
   logic [TIW-1:0]         hit_idx_ff, hit_idx_in;
   logic [30:0]            hit_cnt_ff, hit_cnt_in;
   logic                   free_ok_ff, free_ok_in;
   logic [TIW-1:0]         free_idx_ff, free_idx_in;

   logic               ram_we;
   logic [TIW-1:0]     ram_waddr;
   logic [RW-1:0]      ram_wdata;
   logic [RW-1:0]      ram_rdata;
   logic [31:0]        rd_key;
   logic [30:0]        rd_cnt;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_key_ff, rsp_key_in;
   logic signed [31:0] rsp_count_ff, rsp_count_in;
   logic signed [31:0] rsp_delta_ff, rsp_delta_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [2:0]         kind2_ff, kind2_in;

   logic [31:0]        sel_key;
   logic signed [31:0] sel_sum;
   logic signed [32:0] padd_w;
   logic signed [31:0] padd_sat;
   logic signed [32:0] nc_w;
   logic signed [31:0] nc_sat;
   logic               nc_le0;

   bkrc_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (tidx_ff[TIW-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_key = ram_rdata[RW-1:31];
   assign rd_cnt = ram_rdata[30:0];

   // pending entry under the pointer and saturating sums
   always_comb begin
      sel_key = pkeys_ff[pidx_ff[PIW-1:0]];
      sel_sum = psums_ff[pidx_ff[PIW-1:0]];
      padd_w  = {sel_sum[31], sel_sum} + {sum_ff[31], sum_ff};
      if (padd_w[32] != padd_w[31]) begin
         padd_sat = padd_w[32] ? SAT_MIN : SAT_MAX;
      end else begin
         padd_sat = padd_w[31:0];
      end
      nc_w = $signed({2'b00, hit_cnt_ff}) + $signed({sum_ff[31], sum_ff});
      if (!nc_w[32] && nc_w[31]) begin
         nc_sat = SAT_MAX;
      end else begin
         nc_sat = nc_w[31:0];
      end
      nc_le0 = nc_w[32] || (nc_w == 33'sd0);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      sum_in       = sum_ff;
      used_in      = used_ff;
      pidx_in      = pidx_ff;
      valid_in     = valid_ff;
      tidx_in      = tidx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      kind2_in     = kind2_ff;
      pwr_en       = 1'b0;
      pwr_idx      = used_ff[PIW-1:0];
      pwr_key      = key_ff;
      pwr_sum      = sum_ff;
      ram_we       = 1'b0;
      ram_waddr    = free_idx_ff;
      ram_wdata    = {key_ff, sum_ff[30:0]};
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_DONE;
      rsp_key_in   = key_ff;
      rsp_count_in = '0;
      rsp_delta_in = '0;
      rsp_last_in  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = req_cmd;
               key_in     = req_key;
               sum_in     = req_delta;
               pidx_in    = '0;
               tidx_in    = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               priority if (req_cmd == CMD_ADD) begin
                  if (req_delta != 32'sd0) state_in = ST_P_SCAN;
               end else if (req_cmd == CMD_COMMIT) begin
                  state_in = ST_C_NEXT;
               end else if (req_cmd == CMD_QUERY) begin
                  state_in = ST_T_SCAN;
               end else begin
                  // drop the unused command
                  state_in = ST_IDLE;
               end
            end
         end
         ST_P_SCAN: begin
            // compare one pending entry per cycle
            if (pidx_ff == used_ff) begin
               state_in = ST_IDLE;
               if (used_ff == PCW'(PENDING_DEPTH)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_PEND_FULL;
                  rsp_delta_in = sum_ff;
                  rsp_last_in  = 1'b1;
               end else begin
                  pwr_en  = 1'b1;
                  used_in = used_ff + PCW'(1);
               end
            end else if (sel_key == key_ff) begin
               pwr_en   = 1'b1;
               pwr_idx  = pidx_ff[PIW-1:0];
               pwr_sum  = padd_sat;
               state_in = ST_IDLE;
            end else begin
               pidx_in = pidx_ff + PCW'(1);
            end
         end
         ST_C_NEXT: begin
            // load the next pending entry, skip net-zero sums
            if (pidx_ff == used_ff) begin
               used_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DONE;
               rsp_key_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               pidx_in = pidx_ff + PCW'(1);
               if (sel_sum != 32'sd0) begin
                  key_in     = sel_key;
                  sum_in     = sel_sum;
                  tidx_in    = '0;
                  found_in   = 1'b0;
                  free_ok_in = 1'b0;
                  state_in   = ST_T_SCAN;
               end
            end
         end
         ST_T_SCAN: begin
            // issue one table read per cycle, check the previous one
            if (tidx_ff != TCW'(TABLE_DEPTH)) begin
               chk_vld_in = 1'b1;
               chk_idx_in = tidx_ff[TIW-1:0];
               tidx_in    = tidx_ff + TCW'(1);
            end
            if (chk_vld_ff) begin
               if (valid_ff[chk_idx_ff] && rd_key == key_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_cnt_in = rd_cnt;
                  chk_vld_in = 1'b0;
                  state_in   = ST_RESOLVE;
               end else if (!valid_ff[chk_idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end else if (tidx_ff == TCW'(TABLE_DEPTH)) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            state_in = ST_C_NEXT;
            if (cmd_ff == CMD_QUERY) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_QUERY;
               rsp_count_in = found_ff ? $signed({1'b0, hit_cnt_ff}) : 32'sd0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else if (found_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHANGED;
               rsp_count_in = nc_sat;
               rsp_delta_in = sum_ff;
               if (nc_le0) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  kind2_in             = KIND_DESTROYED;
                  state_in             = ST_EMIT2;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = hit_idx_ff;
                  ram_wdata = {key_ff, nc_sat[30:0]};
               end
            end else if (!sum_ff[31]) begin
               rsp_valid_in = 1'b1;
               rsp_delta_in = sum_ff;
               if (free_ok_ff) begin
                  ram_we                = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  rsp_kind_in           = KIND_CREATED;
                  rsp_count_in          = sum_ff;
                  kind2_in              = KIND_CHANGED;
                  state_in              = ST_EMIT2;
               end else begin
                  rsp_kind_in = KIND_TAB_FULL;
               end
            end
         end
         ST_EMIT2: begin
            // repeat the held result under its second kind
            rsp_valid_in = 1'b1;
            rsp_kind_in  = kind2_ff;
            rsp_key_in   = rsp_key_ff;
            rsp_count_in = rsp_count_ff;
            rsp_delta_in = rsp_delta_ff;
            state_in     = ST_C_NEXT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         valid_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      sum_ff      <= sum_in;
      pidx_ff     <= pidx_in;
      tidx_ff     <= tidx_in;
      chk_idx_ff  <= chk_idx_in;
      found_ff    <= found_in;
      hit_idx_ff  <= hit_idx_in;
      hit_cnt_ff  <= hit_cnt_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      kind2_ff    <= kind2_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_count_ff <= rsp_count_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_last_ff  <= rsp_last_in;
      if (pwr_en) begin
         pkeys_ff[pwr_idx] <= pwr_key;
         psums_ff[pwr_idx] <= pwr_sum;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_entry_key     = rsp_key_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_applied_delta = rsp_delta_ff;
   assign rsp_last          = rsp_last_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= PCW'(PENDING_DEPTH))
      else $error("pending fill beyond depth");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_last && !busy && used_ff == '0)
      else $error("commit done without last or with pending left");

   a_second_event: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT2 |=> rsp_valid && $stable(rsp_entry_key))
      else $error("second event of a pair lost");

endmodule

`default_nettype wire
